[rtl/dfr_pkg.sv]
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants, types and state encodings of the DLE framed receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int MAX_PAYLOAD = FRAME_BYTES - 1;
  localparam int CNT_W       = $clog2(FRAME_BYTES);
  localparam int RAM_AW      = CNT_W + 1;
  localparam int RAM_DEPTH   = 2 * (2 ** CNT_W);
  localparam int POS_W       = 5;

  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;

  typedef enum logic [1:0] {
    P_IDLE,
    P_OPEN,
    P_BODY,
    P_ESC
  } parse_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_SHOW
  } back_state_t;

  // one accepted frame waiting to be sent out
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] len;
    logic             is_short;
  } frame_desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

[rtl/dle_framed_receiver_with_address_filter.sv]
// ----------------------------------------------------------------------------
// dle_framed_receiver_with_address_filter
// DLE STX / DLE ETX deframer with station address filter.
// ----------------------------------------------------------------------------
// Input: one byte per cycle; stalls only while both store banks hold
//   accepted frames that have not been fully sent.
// Output: a frame is queued at its closing ETX transfer; the sender leaves
//   idle, reads each byte from the store, then shows it, and idles per frame.
// Reset (rst, synchronous): parser to idle, byte count zero, queue empty,
//   sender idle, address zero; the frame store is not cleared.
module dle_framed_receiver_with_address_filter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [15:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic [4:0] byte_position,
  output logic       last_byte,
  output logic [4:0] frame_length,
  output logic       short_frame
);

  logic [15:0] station_address;
  dfr_pkg::queue_status_t q_status;
  dfr_pkg::frame_desc_t   push_desc, head;
  logic push, pop;
  logic we, re;
  logic [dfr_pkg::RAM_AW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= '0;
    end else if (cfg_valid) begin
      station_address <= cfg_data;
    end
  end

  dfr_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .station_address (station_address),
    .q_status        (q_status),
    .push            (push),
    .push_desc       (push_desc),
    .we              (we),
    .waddr           (waddr),
    .wdata           (wdata)
  );

  dfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  dfr_ram #(
    .WIDTH (8),
    .DEPTH (dfr_pkg::RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  dfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .re            (re),
    .raddr         (raddr),
    .rdata         (rdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .last_byte     (last_byte),
    .frame_length  (frame_length),
    .short_frame   (short_frame)
  );

endmodule

[rtl/dfr_ram.sv]
// ----------------------------------------------------------------------------
// dfr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/dfr_front.sv]
// ----------------------------------------------------------------------------
// dfr_front
// Byte parser: finds DLE STX ... DLE ETX, unstuffs doubled DLE, writes the
// payload into the current bank and checks the station address at the end.
// ----------------------------------------------------------------------------
module dfr_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                rx_byte,
  input  logic [15:0]               station_address,
  input  dfr_pkg::queue_status_t    q_status,
  output logic                      push,
  output dfr_pkg::frame_desc_t      push_desc,
  output logic                      we,
  output logic [dfr_pkg::RAM_AW-1:0] waddr,
  output logic [7:0]                wdata
);

  dfr_pkg::parse_state_t state, state_next;
  logic [dfr_pkg::CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0] first_byte, second_byte;
  logic       wr_bank;
  logic       fire;
  logic       room_left;
  logic       addr_ok;

  assign in_ready  = !q_status.full;
  assign fire      = in_valid && in_ready;
  assign room_left = byte_count < dfr_pkg::CNT_W'(dfr_pkg::MAX_PAYLOAD);

  always_comb begin
    if (byte_count == '0) begin
      addr_ok = 1'b0;
    end else if (byte_count == dfr_pkg::CNT_W'(1)) begin
      addr_ok = first_byte[3:0] == station_address[3:0];
    end else begin
      addr_ok = (first_byte == station_address[15:8]) &&
                (second_byte == station_address[7:0]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (fire) begin
      unique case (state)
        dfr_pkg::P_IDLE: begin
          if (rx_byte == dfr_pkg::SYM_DLE) begin
            state_next = dfr_pkg::P_OPEN;
          end
        end
        dfr_pkg::P_OPEN: begin
          state_next = (rx_byte == dfr_pkg::SYM_STX) ? dfr_pkg::P_BODY : dfr_pkg::P_IDLE;
        end
        dfr_pkg::P_BODY: begin
          if (rx_byte == dfr_pkg::SYM_DLE) begin
            state_next = dfr_pkg::P_ESC;
          end else if (!room_left) begin
            state_next = dfr_pkg::P_IDLE;
          end
        end
        dfr_pkg::P_ESC: begin
          if (rx_byte == dfr_pkg::SYM_DLE && room_left) begin
            state_next = dfr_pkg::P_BODY;
          end else begin
            state_next = dfr_pkg::P_IDLE;
          end
        end
        default: state_next = dfr_pkg::P_IDLE;
      endcase
    end
  end

  // store writes, byte count and frame hand-off
  always_comb begin
    we              = 1'b0;
    push            = 1'b0;
    byte_count_next = byte_count;
    if (fire) begin
      unique case (state)
        dfr_pkg::P_IDLE: ;
        dfr_pkg::P_OPEN: begin
          if (rx_byte == dfr_pkg::SYM_STX) begin
            byte_count_next = '0;
          end
        end
        dfr_pkg::P_BODY: begin
          if (rx_byte != dfr_pkg::SYM_DLE && room_left) begin
            we = 1'b1;
          end
        end
        dfr_pkg::P_ESC: begin
          if (rx_byte == dfr_pkg::SYM_DLE) begin
            we = room_left;
          end else if (rx_byte == dfr_pkg::SYM_ETX && addr_ok) begin
            push = 1'b1;
          end
        end
        default: ;
      endcase
      if (we) begin
        byte_count_next = byte_count + dfr_pkg::CNT_W'(1);
      end
    end
  end

  assign waddr              = {wr_bank, byte_count};
  assign wdata              = rx_byte;
  assign push_desc.bank     = wr_bank;
  assign push_desc.len      = byte_count;
  assign push_desc.is_short = byte_count == dfr_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dfr_pkg::P_IDLE;
      byte_count <= '0;
      wr_bank    <= 1'b0;
    end else begin
      state      <= state_next;
      byte_count <= byte_count_next;
      if (push) begin
        wr_bank <= !wr_bank;
      end
    end
  end

  // first two payload bytes kept for the address check
  always_ff @(posedge clk) begin
    if (we && byte_count == '0) begin
      first_byte <= rx_byte;
    end
    if (we && byte_count == dfr_pkg::CNT_W'(1)) begin
      second_byte <= rx_byte;
    end
  end

endmodule

[rtl/dfr_queue.sv]
// ----------------------------------------------------------------------------
// dfr_queue
// Two-entry queue of accepted frame descriptors, one per store bank.
// ----------------------------------------------------------------------------
module dfr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  dfr_pkg::frame_desc_t   push_desc,
  input  logic                   pop,
  output dfr_pkg::frame_desc_t   head,
  output dfr_pkg::queue_status_t status
);

  dfr_pkg::frame_desc_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head         = entries[rd_ptr];
  assign status.empty = count == 2'd0;
  assign status.full  = count == 2'd2;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/dfr_back.sv]
// ----------------------------------------------------------------------------
// dfr_back
// Frame sender: reads an accepted frame out of its bank and presents it
// one byte per transfer with position, length and last marker.
// ----------------------------------------------------------------------------
module dfr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  dfr_pkg::frame_desc_t       head,
  input  dfr_pkg::queue_status_t     q_status,
  output logic                       pop,
  output logic                       re,
  output logic [dfr_pkg::RAM_AW-1:0] raddr,
  input  logic [7:0]                 rdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 frame_byte,
  output logic [dfr_pkg::POS_W-1:0]  byte_position,
  output logic                       last_byte,
  output logic [dfr_pkg::POS_W-1:0]  frame_length,
  output logic                       short_frame
);

  dfr_pkg::back_state_t state, state_next;
  logic [dfr_pkg::CNT_W-1:0] idx;
  logic is_last;

  assign is_last = idx == head.len - dfr_pkg::CNT_W'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      dfr_pkg::B_IDLE: begin
        if (!q_status.empty) begin
          state_next = dfr_pkg::B_FETCH;
        end
      end
      dfr_pkg::B_FETCH: state_next = dfr_pkg::B_SHOW;
      dfr_pkg::B_SHOW: begin
        if (out_ready) begin
          state_next = is_last ? dfr_pkg::B_IDLE : dfr_pkg::B_FETCH;
        end
      end
      default: state_next = dfr_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    re        = 1'b0;
    out_valid = 1'b0;
    pop       = 1'b0;
    unique case (state)
      dfr_pkg::B_IDLE: ;
      dfr_pkg::B_FETCH: re = 1'b1;
      dfr_pkg::B_SHOW: begin
        out_valid = 1'b1;
        pop       = out_ready && is_last;
      end
      default: ;
    endcase
  end

  assign raddr         = {head.bank, idx};
  // read data register holds while no read is issued
  assign frame_byte    = rdata;
  assign byte_position = dfr_pkg::POS_W'(idx);
  assign last_byte     = is_last;
  assign frame_length  = dfr_pkg::POS_W'(head.len);
  assign short_frame   = head.is_short;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfr_pkg::B_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == dfr_pkg::B_IDLE) begin
        idx <= '0;
      end else if (state == dfr_pkg::B_SHOW && out_ready) begin
        idx <= idx + dfr_pkg::CNT_W'(1);
      end
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DLE framed receiver. A short table of byte
// sequences covers the framing corner cases, then phases of random traffic
// run under several station addresses. Every output transfer is checked
// against a behavioral deframer kept in step with the accepted input bytes.
// ----------------------------------------------------------------------------
module tb;

  localparam int          SETTLE      = 100;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PHASE_ITEMS = 56;
  localparam logic [7:0]  FILLER      = 8'h55;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [4:0] byte_position;
    logic       last_byte;
    logic [4:0] frame_length;
    logic       short_frame;
  } frame_out_t;

  // byte k of a row sits at seq[63-8*k -: 8]
  typedef struct packed {
    logic [63:0] seq;
    logic [3:0]  n;
    logic        typed;
    logic        one_out;
    logic [7:0]  t_byte;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [6] = '{
    // one-byte frame, low nibble matches address zero
    '{{dfr_pkg::SYM_DLE, dfr_pkg::SYM_STX, 8'hA0, dfr_pkg::SYM_DLE, dfr_pkg::SYM_ETX,
       24'h0}, 4'd5, 1'b1, 1'b1, 8'hA0},
    // empty frame is rejected
    '{{dfr_pkg::SYM_DLE, dfr_pkg::SYM_STX, dfr_pkg::SYM_DLE, dfr_pkg::SYM_ETX, 32'h0},
      4'd4, 1'b1, 1'b0, 8'h00},
    // opening DLE not followed by STX, then a stray byte while idle
    '{{dfr_pkg::SYM_DLE, dfr_pkg::SYM_DLE, dfr_pkg::SYM_STX, 40'h0},
      4'd3, 1'b1, 1'b0, 8'h00},
    // long frame with a doubled DLE, matches address zero
    '{{dfr_pkg::SYM_DLE, dfr_pkg::SYM_STX, 8'h00, 8'h00, dfr_pkg::SYM_DLE,
       dfr_pkg::SYM_DLE, dfr_pkg::SYM_DLE, dfr_pkg::SYM_ETX},
      4'd8, 1'b0, 1'b0, 8'h00},
    // DLE followed by a plain byte drops the frame
    '{{dfr_pkg::SYM_DLE, dfr_pkg::SYM_STX, dfr_pkg::SYM_DLE, FILLER, 32'h0},
      4'd4, 1'b1, 1'b0, 8'h00},
    // one-byte frame with the wrong low nibble
    '{{dfr_pkg::SYM_DLE, dfr_pkg::SYM_STX, 8'hFF, dfr_pkg::SYM_DLE, dfr_pkg::SYM_ETX,
       24'h0}, 4'd5, 1'b1, 1'b0, 8'h00}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  frame_byte;
  logic [4:0]  byte_position;
  logic        last_byte;
  logic [4:0]  frame_length;
  logic        short_frame;

  dle_framed_receiver_with_address_filter u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .last_byte     (last_byte),
    .frame_length  (frame_length),
    .short_frame   (short_frame)
  );

  // deframer state, advanced on every accepted input byte
  dfr_pkg::parse_state_t parse_st;
  int           held;
  logic [7:0]   payload_store [dfr_pkg::MAX_PAYLOAD];
  logic [15:0]  station;

  frame_out_t   pending_bytes [$];
  logic [7:0]   frame_body [$];
  int           mismatches;
  int           items_sent;
  bit           hand_typed;
  bit           calm;
  int           hold_token;
  int           hold_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("dle_framed_receiver_with_address_filter test failed");
    $finish;
  end

  task automatic deframe_byte(input logic [7:0] b);
    logic       addr_hit;
    frame_out_t r;
    case (parse_st)
      dfr_pkg::P_IDLE: begin
        if (b == dfr_pkg::SYM_DLE) parse_st = dfr_pkg::P_OPEN;
      end
      dfr_pkg::P_OPEN: begin
        if (b == dfr_pkg::SYM_STX) begin
          held = 0;
          parse_st = dfr_pkg::P_BODY;
        end else begin
          parse_st = dfr_pkg::P_IDLE;
        end
      end
      dfr_pkg::P_BODY: begin
        if (b == dfr_pkg::SYM_DLE) begin
          parse_st = dfr_pkg::P_ESC;
        end else if (held == dfr_pkg::MAX_PAYLOAD) begin
          parse_st = dfr_pkg::P_IDLE;
        end else begin
          payload_store[held] = b;
          held++;
        end
      end
      default: begin
        if (b == dfr_pkg::SYM_DLE) begin
          if (held == dfr_pkg::MAX_PAYLOAD) begin
            parse_st = dfr_pkg::P_IDLE;
          end else begin
            payload_store[held] = b;
            held++;
            parse_st = dfr_pkg::P_BODY;
          end
        end else begin
          if (held == 1)
            addr_hit = payload_store[0][3:0] == station[3:0];
          else
            addr_hit = held > 1 && payload_store[0] == station[15:8] &&
                       payload_store[1] == station[7:0];
          if (b == dfr_pkg::SYM_ETX && addr_hit && !hand_typed) begin
            for (int k = 0; k < held; k++) begin
              r.frame_byte    = payload_store[k];
              r.byte_position = 5'(k);
              r.last_byte     = (k == held - 1);
              r.frame_length  = 5'(held);
              r.short_frame   = (held == 1);
              pending_bytes.push_back(r);
            end
          end
          parse_st = dfr_pkg::P_IDLE;
        end
      end
    endcase
  endtask

  // returns just after the rising edge that took the byte
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!calm)
      while ($urandom_range(99) < 32) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    deframe_byte(b);
  endtask

  task automatic drop_valid;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_stuffed(input bit close);
    send_byte(dfr_pkg::SYM_DLE);
    send_byte(dfr_pkg::SYM_STX);
    foreach (frame_body[k]) begin
      if (frame_body[k] == dfr_pkg::SYM_DLE) send_byte(dfr_pkg::SYM_DLE);
      send_byte(frame_body[k]);
    end
    if (close) begin
      send_byte(dfr_pkg::SYM_DLE);
      send_byte(dfr_pkg::SYM_ETX);
    end
  endtask

  function automatic logic [7:0] pick_byte;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return dfr_pkg::SYM_DLE;
    if (r < 25) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic build_match(input int len);
    frame_body.delete();
    for (int k = 0; k < len; k++) frame_body.push_back(pick_byte());
    if (len == 1) begin
      frame_body[0][3:0] = station[3:0];
    end else begin
      frame_body[0] = station[15:8];
      frame_body[1] = station[7:0];
    end
  endtask

  // bring the parser back to idle, let the output side drain, then write
  task automatic settle_and_configure(input logic [15:0] addr);
    while (parse_st != dfr_pkg::P_IDLE)
      send_byte((parse_st == dfr_pkg::P_BODY) ? dfr_pkg::SYM_DLE : FILLER);
    drop_valid();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    station = addr;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_traffic(input int target);
    int          start;
    int unsigned r;
    int unsigned pick;
    int          len;
    logic [7:0]  b;
    start = items_sent;
    while (items_sent - start < target) begin
      r = $urandom_range(99);
      if (r < 60) begin
        pick = $urandom_range(99);
        if (pick < 10)      len = 1;
        else if (pick < 88) len = $urandom_range(2, 8);
        else if (pick < 96) len = $urandom_range(9, dfr_pkg::MAX_PAYLOAD);
        else len = $urandom_range(dfr_pkg::FRAME_BYTES, dfr_pkg::FRAME_BYTES + 1);
        build_match(len);
        send_stuffed(1'b1);
      end else if (r < 75) begin
        frame_body.delete();
        len = $urandom_range(0, 8);
        for (int k = 0; k < len; k++) frame_body.push_back(pick_byte());
        send_stuffed(1'b1);
      end else if (r < 85) begin
        frame_body.delete();
        len = $urandom_range(0, 5);
        for (int k = 0; k < len; k++) frame_body.push_back(pick_byte());
        send_stuffed(1'b0);
        send_byte(dfr_pkg::SYM_DLE);
        do b = 8'($urandom_range(255));
        while (b == dfr_pkg::SYM_DLE || b == dfr_pkg::SYM_ETX);
        send_byte(b);
      end else if (r < 92) begin
        send_byte(dfr_pkg::SYM_DLE);
        do b = pick_byte(); while (b == dfr_pkg::SYM_STX);
        send_byte(b);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // output side: random stalls, plus one long hold-off when asked
  initial begin
    out_ready = 1'b0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready = calm || ($urandom_range(99) >= 32);
      end
    end
  end

  // check every output transfer against the oldest expected byte
  initial begin
    frame_out_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected output transfer: frame_byte %0h", frame_byte);
          mismatches++;
        end else begin
          want = pending_bytes.pop_front();
          if (frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %0h, got %0h", want.frame_byte, frame_byte);
            mismatches++;
          end
          if (byte_position !== want.byte_position) begin
            $error("byte_position: expected %0d, got %0d", want.byte_position,
                   byte_position);
            mismatches++;
          end
          if (last_byte !== want.last_byte) begin
            $error("last_byte: expected %0d, got %0d", want.last_byte, last_byte);
            mismatches++;
          end
          if (frame_length !== want.frame_length) begin
            $error("frame_length: expected %0d, got %0d", want.frame_length,
                   frame_length);
            mismatches++;
          end
          if (short_frame !== want.short_frame) begin
            $error("short_frame: expected %0d, got %0d", want.short_frame,
                   short_frame);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    logic [15:0] addrs [5];
    frame_out_t  t;
    rst        = 1'b1;
    in_valid   = 1'b0;
    rx_byte    = 8'h00;
    cfg_valid  = 1'b0;
    cfg_data   = 16'h0000;
    parse_st   = dfr_pkg::P_IDLE;
    held       = 0;
    station    = 16'h0000;
    mismatches = 0;
    items_sent = 0;
    hand_typed = 1'b0;
    calm       = 1'b0;
    hold_token = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIR_ROWS[i]) begin
      hand_typed = DIR_ROWS[i].typed;
      for (int k = 0; k < DIR_ROWS[i].n; k++)
        send_byte(DIR_ROWS[i].seq[63 - 8*k -: 8]);
      if (DIR_ROWS[i].typed && DIR_ROWS[i].one_out) begin
        t = '{DIR_ROWS[i].t_byte, 5'd0, 1'b1, 5'd1, 1'b1};
        pending_bytes.push_back(t);
      end
      hand_typed = 1'b0;
    end

    // 0x1002 puts DLE and STX into the address bytes themselves
    addrs = '{16'hFFFF, 16'h0000, 16'($urandom_range(65535)), 16'h1002,
              16'($urandom_range(65535))};
    foreach (addrs[p]) begin
      settle_and_configure(addrs[p]);
      calm = (p == 2);
      if (p == 1) begin
        // receiver stalls while matching frames keep coming, input backs up
        hold_token++;
        calm = 1'b1;
        repeat (5) begin
          build_match($urandom_range(3, 5));
          send_stuffed(1'b1);
        end
        calm = 1'b0;
      end
      run_traffic(PHASE_ITEMS);
    end

    drop_valid();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("dle_framed_receiver_with_address_filter test passed");
    else
      $display("dle_framed_receiver_with_address_filter test failed");
    $finish;
  end

endmodule
